// ----- sv/mcr_pkg.sv -----
`default_nettype none
package mcr_pkg;

    localparam int MaxMappingsDef = 16;

    localparam logic [2:0] ACT_EVENT    = 3'd0;
    localparam logic [2:0] ACT_ADD      = 3'd1;
    localparam logic [2:0] ACT_REMOVE   = 3'd2;
    localparam logic [2:0] ACT_RM_PARAM = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;
    localparam logic [2:0] ACT_LEARN    = 3'd5;
    localparam logic [2:0] ACT_CANCEL   = 3'd6;

    localparam logic [2:0] K_SET     = 3'd0;
    localparam logic [2:0] K_TOGGLE  = 3'd1;
    localparam logic [2:0] K_LEARNED = 3'd2;
    localparam logic [2:0] K_DONE    = 3'd3;
    localparam logic [2:0] K_FULL    = 3'd4;

    localparam logic [1:0] TK_BYPASS = 2'd2;
    localparam logic [1:0] TK_PARAM  = 2'd3;

    localparam logic [1:0] M_EXACT = 2'd0;
    localparam logic [1:0] M_ROUTE = 2'd1;
    localparam logic [1:0] M_PARAM = 2'd2;

    typedef struct packed {
        logic [6:0] cc;
        logic [4:0] chan;
        logic [1:0] tkind;
        logic [7:0] tid;
        logic [7:0] pid;
    } t_entry;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] cc;
        logic [4:0] chan;
        logic [3:0] evchan;
        logic [7:0] tid;
        logic [7:0] pid;
    } t_key;

    typedef struct packed {
        logic shift;
        logic load;
        logic wr_pressed;
        logic pressed_val;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  tk;
        logic [7:0]  tid;
        logic [7:0]  pid;
        logic [15:0] level;
    } t_result;

    // round(v * 32768 / 127), with 32768 = 127 * 258 + 2
    function automatic logic [15:0] cc_level(input logic [6:0] v);
        logic [8:0]  t;
        logic [15:0] base;
        begin
            t    = {1'b0, v, 1'b0} + 9'd63;
            base = {9'b0, v} * 16'd258;
            if (t >= 9'd254) begin
                cc_level = base + 16'd2;
            end else if (t >= 9'd127) begin
                cc_level = base + 16'd1;
            end else begin
                cc_level = base;
            end
        end
    endfunction

endpackage
`default_nettype wire

// ----- sv/mcr_if.sv -----
`default_nettype none
interface mcr_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        action;
    logic [7:0]        status_byte;
    logic [6:0]        cc_num;
    logic [6:0]        cc_val;
    logic signed [4:0] map_channel;
    logic [1:0]        target_kind;
    logic [7:0]        target_id;
    logic [7:0]        param_id;
    logic [5:0]        entry_index;

    modport source (output valid, action, status_byte, cc_num, cc_val, map_channel,
                    target_kind, target_id, param_id, entry_index, input ready);
    modport sink (input valid, action, status_byte, cc_num, cc_val, map_channel,
                  target_kind, target_id, param_id, entry_index, output ready);
endinterface

interface mcr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  out_target_kind;
    logic [7:0]  out_target_id;
    logic [7:0]  out_param_id;
    logic [15:0] level;
    logic        last;

    modport source (output valid, kind, out_target_kind, out_target_id, out_param_id,
                    level, last, input ready);
    modport sink (input valid, kind, out_target_kind, out_target_id, out_param_id,
                  level, last, output ready);
endinterface
`default_nettype wire

// ----- sv/mcr_cell.sv -----
`default_nettype none
module mcr_cell
    import mcr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_entry     i_next,
    input  wire        i_next_pressed,
    input  t_entry     i_new,
    input  t_key       i_key,
    output t_entry     o_entry,
    output logic       o_pressed,
    output logic       o_match
);

    t_entry r_entry;
    logic   r_pressed;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.load) begin
            r_entry <= i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
        end else if (i_ctl.shift) begin
            r_pressed <= i_next_pressed;
        end else if (i_ctl.load) begin
            r_pressed <= 1'b0;
        end else if (i_ctl.wr_pressed) begin
            r_pressed <= i_ctl.pressed_val;
        end
    end

    always_comb begin
        case (i_key.mode)
            M_EXACT: o_match = (r_entry.cc == i_key.cc) && (r_entry.chan == i_key.chan);
            M_ROUTE: o_match = (r_entry.cc == i_key.cc) &&
                               (r_entry.chan[4] || (r_entry.chan == {1'b0, i_key.evchan}));
            M_PARAM: o_match = (r_entry.tkind == TK_PARAM) && (r_entry.tid == i_key.tid) &&
                               (r_entry.pid == i_key.pid);
            default: o_match = 1'b0;
        endcase
    end

    assign o_entry   = r_entry;
    assign o_pressed = r_pressed;

endmodule
`default_nettype wire

// ----- sv/midi_cc_mapping_router_core.sv -----
// MIDI control-change mapping router.
// i_in (sink) takes one action per transfer: event, add, remove_at,
// remove_param_target, clear, learn arm, learn cancel. o_out (source)
// gives zero, one or two results per action, last set on the final one.
// The mapping table is a row of cells; deletion shifts every cell above
// the removed place down by one all at once, append loads one cell.
// Event routing and the add / remove searches step through the cells one
// per cycle, but a routing search pauses while a stalled receiver blocks it.
// i_in.ready is high only while no item is in progress; the result
// register lets the next item be taken while the last result waits.
// A stalled receiver holds the result register and pauses the search
// when a further result has to leave.
// Reset (synchronous, i_rst_n low) empties the table and disarms learn;
// no clearing pass is needed.
`default_nettype none
module midi_cc_mapping_router_core
    import mcr_pkg::*;
#(
    parameter int MAX_MAPPINGS = MaxMappingsDef
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mcr_in_if.sink     i_in,
    mcr_out_if.source  o_out
);

    localparam int IW = $clog2(MAX_MAPPINGS);
    localparam int CW = $clog2(MAX_MAPPINGS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEL   = 3'd2;
    localparam logic [2:0] S_APP   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_del, n_del;
    logic [1:0]    r_n, n_n;
    logic          r_learn, n_learn;
    t_key          r_key, n_key;
    t_entry        r_new, n_new;
    logic [6:0]    r_val, n_val;
    logic          r_armed, n_armed;
    logic [1:0]    r_lkind, n_lkind;
    logic [7:0]    r_ltarget, n_ltarget;
    logic [7:0]    r_lparam, n_lparam;
    t_result       r_resp, n_resp;
    t_result       r_pend, n_pend;
    logic          r_pend_v, n_pend_v;
    t_result       r_out, n_out;
    logic          r_out_v, n_out_v;
    logic          r_out_last, n_out_last;

    t_entry        w_entry [MAX_MAPPINGS];
    logic          w_pressed [MAX_MAPPINGS];
    logic          w_match [MAX_MAPPINGS];
    t_cell_ctl     w_ctl [MAX_MAPPINGS];

    logic [IW-1:0] w_sel;
    t_entry        w_se;
    logic          w_sp;
    logic          w_sm;
    logic          w_pr;
    logic          w_byp;
    logic          w_need;
    logic          w_can_put;
    logic          w_wr_pr;
    logic [4:0]    w_mchan;

    genvar g;
    generate
        for (g = 0; g < MAX_MAPPINGS; g++) begin : g_cell
            t_entry w_nx;
            logic   w_nxp;
            if (g + 1 < MAX_MAPPINGS) begin : g_nb
                assign w_nx  = w_entry[g + 1];
                assign w_nxp = w_pressed[g + 1];
            end else begin : g_end
                assign w_nx  = '0;
                assign w_nxp = 1'b0;
            end
            always_comb begin
                w_ctl[g].shift = (r_state == S_DEL) && (CW'(g) >= CW'(r_del)) &&
                                 (CW'(g + 1) < r_count);
                w_ctl[g].load = (r_state == S_APP) && (r_count < CW'(MAX_MAPPINGS)) &&
                                (r_count == CW'(g));
                w_ctl[g].wr_pressed = w_wr_pr && (w_sel == IW'(g));
                w_ctl[g].pressed_val = w_pr;
            end
            mcr_cell u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (w_ctl[g]),
                .i_next         (w_nx),
                .i_next_pressed (w_nxp),
                .i_new          (r_new),
                .i_key          (r_key),
                .o_entry        (w_entry[g]),
                .o_pressed      (w_pressed[g]),
                .o_match        (w_match[g])
            );
        end
    endgenerate

    assign w_sel     = r_ptr[IW-1:0];
    assign w_se      = w_entry[w_sel];
    assign w_sp      = w_pressed[w_sel];
    assign w_sm      = w_match[w_sel];
    assign w_pr      = r_val[6];
    assign w_byp     = (w_se.tkind == TK_BYPASS);
    assign w_need    = w_byp ? (w_pr != w_sp) : 1'b1;
    assign w_can_put = !r_out_v || o_out.ready;
    assign w_mchan   = i_in.map_channel[4] ? 5'b11111 : i_in.map_channel;
    assign w_wr_pr   = (r_state == S_SCAN) && (r_key.mode == M_ROUTE) && (r_ptr < r_count) &&
                       (r_n != 2'd2) && w_sm && w_byp && !(w_need && r_pend_v && !w_can_put);

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_count    = r_count;
        n_del      = r_del;
        n_n        = r_n;
        n_learn    = r_learn;
        n_key      = r_key;
        n_new      = r_new;
        n_val      = r_val;
        n_armed    = r_armed;
        n_lkind    = r_lkind;
        n_ltarget  = r_ltarget;
        n_lparam   = r_lparam;
        n_resp     = r_resp;
        n_pend     = r_pend;
        n_pend_v   = r_pend_v;
        n_out      = r_out;
        n_out_v    = r_out_v && !o_out.ready;
        n_out_last = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_ptr        = '0;
                    n_n          = 2'd0;
                    n_pend_v     = 1'b0;
                    n_learn      = 1'b0;
                    n_val        = i_in.cc_val;
                    n_resp       = '0;
                    n_resp.kind  = K_DONE;
                    n_key.cc     = i_in.cc_num;
                    n_key.evchan = i_in.status_byte[3:0];
                    n_key.tid    = i_in.target_id;
                    n_key.pid    = i_in.param_id;
                    n_new.cc     = i_in.cc_num;
                    n_new.chan   = w_mchan;
                    n_new.tkind  = i_in.target_kind;
                    n_new.tid    = i_in.target_id;
                    n_new.pid    = i_in.param_id;
                    n_key.chan   = w_mchan;
                    case (i_in.action)
                        ACT_EVENT: begin
                            n_state = S_SCAN;
                            if (r_armed) begin
                                n_armed     = 1'b0;
                                n_learn     = 1'b1;
                                n_key.mode  = M_EXACT;
                                n_key.chan  = {1'b0, i_in.status_byte[3:0]};
                                n_new.chan  = {1'b0, i_in.status_byte[3:0]};
                                n_new.tkind = r_lkind;
                                n_new.tid   = r_ltarget;
                                n_new.pid   = r_lparam;
                            end else begin
                                n_key.mode = M_ROUTE;
                            end
                        end
                        ACT_ADD: begin
                            n_key.mode = M_EXACT;
                            n_state    = S_SCAN;
                        end
                        ACT_REMOVE: begin
                            if ({{(CW > 6 ? CW - 6 : 0){1'b0}}, i_in.entry_index} <
                                {{(CW > 6 ? 0 : 6 - CW){1'b0}}, r_count}) begin
                                n_del   = i_in.entry_index[IW-1:0];
                                n_key.mode = M_PARAM;
                                n_state = S_DEL;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        ACT_RM_PARAM: begin
                            n_key.mode = M_PARAM;
                            n_state    = S_SCAN;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        ACT_LEARN: begin
                            n_armed   = 1'b1;
                            n_lkind   = i_in.target_kind;
                            n_ltarget = i_in.target_id;
                            n_lparam  = i_in.param_id;
                            n_state   = S_RESP;
                        end
                        ACT_CANCEL: begin
                            n_armed   = 1'b0;
                            n_ltarget = '0;
                            n_lparam  = '0;
                            n_state   = S_RESP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if ((r_ptr >= r_count) || ((r_key.mode == M_ROUTE) && (r_n == 2'd2))) begin
                    case (r_key.mode)
                        M_ROUTE: n_state = r_pend_v ? S_FLUSH : S_IDLE;
                        M_EXACT: n_state = S_APP;
                        default: n_state = S_RESP;
                    endcase
                end else if (r_key.mode == M_ROUTE) begin
                    if (!w_sm || !w_need) begin
                        n_ptr = r_ptr + 1'b1;
                    end else if (!(r_pend_v && !w_can_put)) begin
                        if (r_pend_v) begin
                            n_out      = r_pend;
                            n_out_v    = 1'b1;
                            n_out_last = 1'b0;
                        end
                        n_pend.kind  = w_byp ? K_TOGGLE : K_SET;
                        n_pend.tk    = w_se.tkind;
                        n_pend.tid   = w_se.tid;
                        n_pend.pid   = w_se.pid;
                        n_pend.level = w_byp ? 16'd0 : cc_level(r_val);
                        n_pend_v     = 1'b1;
                        n_n          = r_n + 1'b1;
                        n_ptr        = r_ptr + 1'b1;
                    end
                end else if (w_sm) begin
                    n_del   = w_sel;
                    n_state = S_DEL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DEL: begin
                n_count = r_count - 1'b1;
                n_state = (r_key.mode == M_EXACT) ? S_APP : S_RESP;
            end
            S_APP: begin
                n_state = S_RESP;
                if (r_count >= CW'(MAX_MAPPINGS)) begin
                    n_resp.kind = K_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    if (r_learn) begin
                        n_resp.kind = K_LEARNED;
                        n_resp.tk   = r_new.tkind;
                        n_resp.tid  = r_new.tid;
                        n_resp.pid  = r_new.pid;
                    end
                end
            end
            S_RESP: begin
                if (w_can_put) begin
                    n_out      = r_resp;
                    n_out_v    = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_can_put) begin
                    n_out      = r_pend;
                    n_out_v    = 1'b1;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_armed   <= 1'b0;
            r_lkind   <= '0;
            r_ltarget <= '0;
            r_lparam  <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_armed   <= n_armed;
            r_lkind   <= n_lkind;
            r_ltarget <= n_ltarget;
            r_lparam  <= n_lparam;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
            r_n       <= n_n;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_del      <= n_del;
        r_learn    <= n_learn;
        r_key      <= n_key;
        r_new      <= n_new;
        r_val      <= n_val;
        r_resp     <= n_resp;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_v;
    assign o_out.kind            = r_out.kind;
    assign o_out.out_target_kind = r_out.tk;
    assign o_out.out_target_id   = r_out.tid;
    assign o_out.out_param_id    = r_out.pid;
    assign o_out.level           = r_out.level;
    assign o_out.last            = r_out_last;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_MAPPINGS))
        else $error("table count beyond capacity");

    a_del_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("delete did not shrink the table");

    a_route_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= 2'd2)
        else $error("more than two routed results");

    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.kind != K_SET)) |-> (r_out.level == 16'd0))
        else $error("level set on a non-value result");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mcr_pkg::*;

    localparam int Depth = MaxMappingsDef;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [6:0] cc;
        logic signed [4:0] chan;
        logic [1:0] tkind;
        logic [7:0] tid;
        logic [7:0] pid;
    } t_map;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  tk;
        logic [7:0]  tid;
        logic [7:0]  pid;
        logic [15:0] level;
        logic        last;
    } t_route_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mcr_in_if  in_ch ();
    mcr_out_if out_ch ();

    midi_cc_mapping_router_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_map       table_q [$];
    logic       pressed_q [$];
    logic       armed;
    logic [1:0] arm_kind;
    logic [7:0] arm_tid;
    logic [7:0] arm_pid;
    t_route_res expected_q [$];

    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_route_res exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result kind %0d", out_ch.kind);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (out_ch.kind !== exp_r.kind) begin
                    $error("kind exp %0d got %0d", exp_r.kind, out_ch.kind); errors++;
                end
                if (out_ch.out_target_kind !== exp_r.tk) begin
                    $error("out_target_kind exp %0d got %0d", exp_r.tk,
                           out_ch.out_target_kind); errors++;
                end
                if (out_ch.out_target_id !== exp_r.tid) begin
                    $error("out_target_id exp %0d got %0d", exp_r.tid,
                           out_ch.out_target_id); errors++;
                end
                if (out_ch.out_param_id !== exp_r.pid) begin
                    $error("out_param_id exp %0d got %0d", exp_r.pid,
                           out_ch.out_param_id); errors++;
                end
                if (out_ch.level !== exp_r.level) begin
                    $error("level exp %0d got %0d", exp_r.level, out_ch.level); errors++;
                end
                if (out_ch.last !== exp_r.last) begin
                    $error("last exp %0d got %0d", exp_r.last, out_ch.last); errors++;
                end
            end
        end
    end

    function automatic t_route_res mk_res(logic [2:0] k, logic [1:0] tk, logic [7:0] tid,
                                          logic [7:0] pid, logic [15:0] lvl);
        t_route_res r;
        r.kind = k; r.tk = tk; r.tid = tid; r.pid = pid; r.level = lvl; r.last = 1'b0;
        return r;
    endfunction

    function automatic logic append_map(t_map m);
        foreach (table_q[i]) begin
            if (table_q[i].cc == m.cc && table_q[i].chan == m.chan) begin
                table_q.delete(i);
                pressed_q.delete(i);
                break;
            end
        end
        if (table_q.size() >= Depth) return 1'b0;
        table_q = {table_q, m};
        pressed_q = {pressed_q, 1'b0};
        return 1'b1;
    endfunction

    task automatic predict_routing(logic [2:0] act, logic [7:0] status, logic [6:0] cc,
                                   logic [6:0] val, logic signed [4:0] mch, logic [1:0] tk,
                                   logic [7:0] tid, logic [7:0] pid, logic [5:0] idx);
        t_route_res res [$];
        t_map m;
        logic [3:0] ch;
        logic pr;
        int unsigned lvl;
        ch = status[3:0];
        case (act)
            ACT_EVENT: begin
                if (armed) begin
                    m.cc = cc; m.chan = {1'b0, ch}; m.tkind = arm_kind;
                    m.tid = arm_tid; m.pid = arm_pid;
                    armed = 1'b0;
                    if (append_map(m)) res = {res, mk_res(K_LEARNED, arm_kind, arm_tid,
                                                          arm_pid, 16'd0)};
                    else res = {res, mk_res(K_FULL, 2'd0, 8'd0, 8'd0, 16'd0)};
                end else begin
                    foreach (table_q[i]) begin
                        if (res.size() >= 2) break;
                        if (table_q[i].cc != cc) continue;
                        if (table_q[i].chan >= 0 && table_q[i].chan != $signed({1'b0, ch}))
                            continue;
                        if (table_q[i].tkind == TK_BYPASS) begin
                            pr = (val >= 7'd64);
                            if (pr != pressed_q[i])
                                res = {res, mk_res(K_TOGGLE, table_q[i].tkind,
                                                   table_q[i].tid, table_q[i].pid, 16'd0)};
                            pressed_q[i] = pr;
                        end else begin
                            lvl = (int'(val) * 32768 + 63) / 127;
                            res = {res, mk_res(K_SET, table_q[i].tkind, table_q[i].tid,
                                               table_q[i].pid, lvl[15:0])};
                        end
                    end
                end
            end
            ACT_ADD: begin
                m.cc = cc; m.chan = (mch < 0) ? -5'sd1 : mch; m.tkind = tk;
                m.tid = tid; m.pid = pid;
                res = {res, mk_res(append_map(m) ? K_DONE : K_FULL, 2'd0, 8'd0, 8'd0,
                                   16'd0)};
            end
            ACT_REMOVE: begin
                if (idx < table_q.size()) begin
                    table_q.delete(idx);
                    pressed_q.delete(idx);
                end
                res = {res, mk_res(K_DONE, 2'd0, 8'd0, 8'd0, 16'd0)};
            end
            ACT_RM_PARAM: begin
                foreach (table_q[i]) begin
                    if (table_q[i].tkind == TK_PARAM && table_q[i].tid == tid &&
                        table_q[i].pid == pid) begin
                        table_q.delete(i);
                        pressed_q.delete(i);
                        break;
                    end
                end
                res = {res, mk_res(K_DONE, 2'd0, 8'd0, 8'd0, 16'd0)};
            end
            ACT_CLEAR: begin
                table_q.delete();
                pressed_q.delete();
                res = {res, mk_res(K_DONE, 2'd0, 8'd0, 8'd0, 16'd0)};
            end
            ACT_LEARN: begin
                armed = 1'b1; arm_kind = tk; arm_tid = tid; arm_pid = pid;
                res = {res, mk_res(K_DONE, 2'd0, 8'd0, 8'd0, 16'd0)};
            end
            ACT_CANCEL: begin
                armed = 1'b0; arm_tid = 8'd0; arm_pid = 8'd0;
                res = {res, mk_res(K_DONE, 2'd0, 8'd0, 8'd0, 16'd0)};
            end
            default: ;
        endcase
        if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        foreach (res[i]) expected_q = {expected_q, res[i]};
    endtask

    task automatic send_action(logic [2:0] act, logic [7:0] status, logic [6:0] cc,
                               logic [6:0] val, logic signed [4:0] mch, logic [1:0] tk,
                               logic [7:0] tid, logic [7:0] pid, logic [5:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.status_byte <= status;
        in_ch.cc_num      <= cc;
        in_ch.cc_val      <= val;
        in_ch.map_channel <= mch;
        in_ch.target_kind <= tk;
        in_ch.target_id   <= tid;
        in_ch.param_id    <= pid;
        in_ch.entry_index <= idx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_routing(act, status, cc, val, mch, tk, tid, pid, idx);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (Depth + 8) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_action(ACT_EVENT, 8'hB0, 7'd1, 7'd10, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_ADD, 8'h00, 7'd0, 7'd0, -5'sd1, 2'd0, 8'd1, 8'd2, 6'd0);
        send_action(ACT_ADD, 8'h00, 7'd127, 7'd0, 5'sd15, 2'd3, 8'hFF, 8'hFF, 6'd0);
        send_action(ACT_ADD, 8'h00, 7'd0, 7'd0, -5'sd16, 2'd1, 8'd3, 8'd4, 6'd0);
        send_action(ACT_ADD, 8'h00, 7'd5, 7'd0, 5'sd2, 2'd2, 8'd7, 8'd8, 6'd0);
        send_action(ACT_ADD, 8'h00, 7'd0, 7'd0, 5'sd3, 2'd3, 8'd9, 8'd9, 6'd0);
        send_action(ACT_EVENT, 8'hB3, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_EVENT, 8'h03, 7'd0, 7'd127, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_EVENT, 8'hFF, 7'd127, 7'd64, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_EVENT, 8'hB2, 7'd5, 7'd64, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_EVENT, 8'hB2, 7'd5, 7'd100, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_EVENT, 8'hB2, 7'd5, 7'd63, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_RM_PARAM, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd9, 8'd9, 6'd0);
        send_action(ACT_RM_PARAM, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd9, 8'd9, 6'd0);
        send_action(ACT_REMOVE, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd63);
        send_action(ACT_REMOVE, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_LEARN, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd3, 8'd42, 8'd43, 6'd0);
        send_action(ACT_EVENT, 8'hBA, 7'd77, 7'd5, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_LEARN, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd1, 8'd1, 8'd1, 6'd0);
        send_action(ACT_CANCEL, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(3'd7, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        for (int i = 0; i < Depth + 1; i++)
            send_action(ACT_ADD, 8'h00, 7'(i + 20), 7'd0, 5'sd1, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_LEARN, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd5, 8'd6, 6'd0);
        send_action(ACT_EVENT, 8'hB1, 7'd99, 7'd1, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        send_action(ACT_CLEAR, 8'h00, 7'd0, 7'd0, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
        drain_results();
    endtask

    task automatic test_random(int n_items);
        logic [2:0] act;
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 45) act = ACT_EVENT;
            else if (r < 75) act = ACT_ADD;
            else if (r < 82) act = ACT_REMOVE;
            else if (r < 87) act = ACT_RM_PARAM;
            else if (r < 89) act = ACT_CLEAR;
            else if (r < 94) act = ACT_LEARN;
            else if (r < 97) act = ACT_CANCEL;
            else act = 3'($urandom_range(7));
            send_action(act, 8'($urandom), 7'($urandom_range(7) * (($urandom_range(9) == 0)
                        ? 18 : 1)), 7'($urandom), 5'($urandom),
                        2'($urandom), 8'($urandom_range(3) * (($urandom_range(9) == 0) ? 85 : 1)),
                        8'($urandom_range(3) * (($urandom_range(9) == 0) ? 85 : 1)),
                        6'(($urandom_range(3) == 0) ? $urandom : $urandom_range(17)));
        end
    endtask

    task automatic test_paused_sender();
        send_action(ACT_ADD, 8'h00, 7'd3, 7'd0, -5'sd1, 2'd1, 8'd1, 8'd1, 6'd0);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        send_action(ACT_EVENT, 8'hB4, 7'd3, 7'd90, 5'sd0, 2'd0, 8'd0, 8'd0, 6'd0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = '0; in_ch.status_byte = '0; in_ch.cc_num = '0;
        in_ch.cc_val = '0; in_ch.map_channel = '0; in_ch.target_kind = '0;
        in_ch.target_id = '0; in_ch.param_id = '0; in_ch.entry_index = '0;
        out_ch.ready = 1'b0;
        armed = 1'b0; arm_kind = '0; arm_tid = '0; arm_pid = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(125);
        send_idle_pct = 48; recv_stall_pct = 0;  test_random(125);
        test_paused_sender();
        send_idle_pct = 0;  recv_stall_pct = 48; test_random(125);
        send_idle_pct = 18; recv_stall_pct = 18; test_random(125);
        drain_results();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
